// ===== rtl/cloud_in_cell_deposit_core_defines.svh =====
// Assertion macros for the cloud-in-cell deposit core.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef CLOUD_IN_CELL_DEPOSIT_CORE_DEFINES_SVH
`define CLOUD_IN_CELL_DEPOSIT_CORE_DEFINES_SVH

// same-cycle implication
`define CICD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CICD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cicd_pkg.sv =====
// Shared constants and types for the cloud-in-cell deposit core.
// No dependencies.
`default_nettype none
package cicd_pkg;

  localparam int POS_W         = 28;
  localparam int RD_W          = 5;
  localparam int CPU_W         = 32;
  localparam int MASS_W        = 32;
  localparam int WHOLE_W       = 20;
  localparam int WQ_W          = 17;
  localparam int GRID_SIDE_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CPU_W-1:0]  CPU_RESET = 32'h0100_0000;
  localparam logic [MASS_W-1:0] MASS_MAX  = 32'hFFFF_FFFF;

  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic              sat;
  } cicd_result_t;

endpackage
`default_nettype wire

// ===== rtl/cicd_queue.sv =====
// Two-entry request queue between front and back.
// Depends on nothing but its width parameter.
`default_nettype none
module cicd_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire  [W-1:0] push_data,
  output logic         full,
  input  wire          pop,
  output logic         valid,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cicd_front.sv =====
// Front end: accepts requests, scales deposit positions and splits them into
// cell indices and fractions, and wraps read indices. Uses cicd_pkg.
`default_nettype none
module cicd_front #(
  parameter int GRID_SIDE = cicd_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = cicd_pkg::FRAC_BITS_DEF,
  parameter int IDX_W     = $clog2(GRID_SIDE),
  parameter int ENTRY_W   = 1 + 6 * IDX_W + 3 * FRAC_BITS
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         clr_done,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         kind,
  input  wire  [cicd_pkg::POS_W-1:0]  pos_x,
  input  wire  [cicd_pkg::POS_W-1:0]  pos_y,
  input  wire  [cicd_pkg::POS_W-1:0]  pos_z,
  input  wire  [cicd_pkg::RD_W-1:0]   read_x,
  input  wire  [cicd_pkg::RD_W-1:0]   read_y,
  input  wire  [cicd_pkg::RD_W-1:0]   read_z,
  input  wire  [cicd_pkg::CPU_W-1:0]  cells_per_unit,
  output logic                        q_push,
  output logic [ENTRY_W-1:0]          q_data,
  input  wire                         q_full
);
  import cicd_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;
  localparam int MOD_CYC = WHOLE_W / 4;
  localparam int MW      = WHOLE_W + $clog2(GRID_SIDE) + 1;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         ax_r;
  logic [2:0]         mcnt_r;
  logic               kind_r;
  logic [POS_W-1:0]   pos_r   [3];
  logic [IDX_W-1:0]   rd_r    [3];
  logic [WHOLE_W-1:0] whole_r [3];
  logic [WHOLE_W-1:0] red     [3];
  logic [FRAC_BITS-1:0] frac_r [3];
  logic [IDX_W-1:0]   lo [3];
  logic [IDX_W-1:0]   hi [3];
  logic [POS_W+CPU_W-1:0] prod;

  function automatic logic [IDX_W-1:0] wrap_read(input logic [RD_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << RD_W); i++) begin
      if (v == RD_W'(i)) r = IDX_W'(i % GRID_SIDE);
    end
    return r;
  endfunction

  assign in_ready = (state_r == F_IDLE) && clr_done;
  assign prod     = pos_r[ax_r] * cells_per_unit;

  always_comb begin
    logic [MW-1:0] r;
    int sh;
    for (int a = 0; a < 3; a++) begin
      r = MW'(whole_r[a]);
      for (int j = 0; j < 4; j++) begin
        sh = WHOLE_W - 1 - 4 * int'(mcnt_r) - j;
        if (r >= (MW'(GRID_SIDE) << sh)) r = r - (MW'(GRID_SIDE) << sh);
      end
      red[a] = r[WHOLE_W-1:0];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo[a] = kind_r ? rd_r[a] : whole_r[a][IDX_W-1:0];
      hi[a] = (lo[a] == IDX_W'(GRID_SIDE - 1)) ? '0 : lo[a] + 1'b1;
    end
    if (kind_r == KIND_READ) begin
      q_data = {KIND_READ, lo[0], lo[1], lo[2], (ENTRY_W - 1 - 3 * IDX_W)'(0)};
    end else begin
      q_data = {KIND_DEPOSIT, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                frac_r[0], frac_r[1], frac_r[2]};
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid && in_ready) state_nxt = (kind == KIND_READ) ? F_PUSH : F_MUL;
      F_MUL:   if (ax_r == 2'd2) state_nxt = F_MOD;
      F_MOD:   if (mcnt_r == 3'(MOD_CYC - 1)) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r   <= kind;
      pos_r[0] <= pos_x;
      pos_r[1] <= pos_y;
      pos_r[2] <= pos_z;
      rd_r[0]  <= wrap_read(read_x);
      rd_r[1]  <= wrap_read(read_y);
      rd_r[2]  <= wrap_read(read_z);
    end
    if (state_r == F_MUL) begin
      whole_r[ax_r] <= prod[POS_W+CPU_W-1 -: WHOLE_W];
      frac_r[ax_r]  <= prod[39 -: FRAC_BITS];
    end
    if (state_r == F_MOD) begin
      for (int a = 0; a < 3; a++) whole_r[a] <= red[a];
    end
    if (!rst_n) begin
      state_r <= F_IDLE;
      ax_r    <= 2'd0;
      mcnt_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= (state_r == F_MUL) ? ax_r + 2'd1 : 2'd0;
      mcnt_r  <= (state_r == F_MOD) ? mcnt_r + 3'd1 : 3'd0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cicd_back.sv =====
// Back end: eight read-modify-write accumulations per deposit into the
// grid memory, cell reads, clearing pass and result register. Uses cicd_pkg.
`default_nettype none
module cicd_back #(
  parameter int GRID_SIDE = cicd_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = cicd_pkg::FRAC_BITS_DEF,
  parameter int IDX_W     = $clog2(GRID_SIDE),
  parameter int ENTRY_W   = 1 + 6 * IDX_W + 3 * FRAC_BITS
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  wire  [ENTRY_W-1:0]     q_data,
  output logic                   q_pop,
  output logic                   clr_busy,
  output logic                   res_valid,
  input  wire                    res_ready,
  output cicd_pkg::cicd_result_t res
);
  import cicd_pkg::*;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int P_W    = 2 * WT_W;
  localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_BITS;

  logic [MASS_W-1:0] mem [CELLS];

  logic               clr_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [ENTRY_W-1:0] ent_r;
  logic               run_r;
  logic [2:0]         cnt_r;
  logic               v1_r, v2_r;
  logic [ADDR_W-1:0]  addr1_r, addr2_r;
  logic [P_W-1:0]     wxy1_r, w2_r;
  logic [WT_W-1:0]    wz1_r;
  logic               last1_r, last2_r, rd1_r, rd2_r;
  logic [MASS_W-1:0]  rdata_r;
  logic               sat_acc_r;
  logic               res_valid_r;
  cicd_result_t       res_r;

  logic               e_read;
  logic [IDX_W-1:0]   lo [3];
  logic [IDX_W-1:0]   hi [3];
  logic [FRAC_BITS-1:0] fr [3];
  logic [IDX_W-1:0]   cx, cy, cz;
  logic [WT_W-1:0]    wx, wy, wz;
  logic [ADDR_W-1:0]  addr;
  logic               start, last;
  logic [WQ_W-1:0]    wq;
  logic [MASS_W:0]    sum;
  logic               sat_now;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [MASS_W-1:0]  mem_wd;

  assign {e_read, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], fr[0], fr[1], fr[2]} = ent_r;

  assign cx   = cnt_r[2] ? hi[0] : lo[0];
  assign cy   = cnt_r[1] ? hi[1] : lo[1];
  assign cz   = cnt_r[0] ? hi[2] : lo[2];
  assign wx   = cnt_r[2] ? WT_W'(fr[0]) : ONE - WT_W'(fr[0]);
  assign wy   = cnt_r[1] ? WT_W'(fr[1]) : ONE - WT_W'(fr[1]);
  assign wz   = cnt_r[0] ? WT_W'(fr[2]) : ONE - WT_W'(fr[2]);
  assign addr = (ADDR_W'(cx) * ADDR_W'(GRID_SIDE) + ADDR_W'(cy)) * ADDR_W'(GRID_SIDE)
                + ADDR_W'(cz);
  assign last = e_read || (cnt_r == 3'd7);

  assign start = q_valid && !clr_r && !run_r && !v1_r && !v2_r && !res_valid_r;
  assign q_pop = start;

  generate
    if (FRAC_BITS >= 16) begin : g_shr
      assign wq = WQ_W'((w2_r >> FRAC_BITS) >> (FRAC_BITS - 16));
    end else begin : g_shl
      assign wq = WQ_W'((w2_r >> FRAC_BITS) << (16 - FRAC_BITS));
    end
  endgenerate

  assign sum     = {1'b0, rdata_r} + (MASS_W + 1)'(wq);
  assign sat_now = sum[MASS_W];

  assign mem_we = clr_r || (v2_r && !rd2_r);
  assign mem_wa = clr_r ? clr_cnt_r : addr2_r;
  assign mem_wd = clr_r ? '0 : (sat_now ? MASS_MAX : sum[MASS_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (v1_r) rdata_r <= mem[addr1_r];
  end

  always_ff @(posedge clk) begin
    if (start) ent_r <= q_data;
    if (run_r) begin
      addr1_r <= addr;
      wxy1_r  <= wx * wy;
      wz1_r   <= wz;
      last1_r <= last;
      rd1_r   <= e_read;
    end
    if (v1_r) begin
      w2_r    <= P_W'(wxy1_r >> FRAC_BITS) * P_W'(wz1_r);
      addr2_r <= addr1_r;
      last2_r <= last1_r;
      rd2_r   <= rd1_r;
    end
    if (v2_r && last2_r) begin
      res_r.mass <= rd2_r ? rdata_r : '0;
      res_r.sat  <= !rd2_r && (sat_acc_r || sat_now);
    end
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      run_r       <= 1'b0;
      cnt_r       <= 3'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sat_acc_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(CELLS - 1)) clr_r <= 1'b0;
      end
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 3'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (last) run_r <= 1'b0;
      end
      v1_r <= run_r;
      v2_r <= v1_r;
      if (start) sat_acc_r <= 1'b0;
      else if (v2_r && !rd2_r && sat_now) sat_acc_r <= 1'b1;
      if (v2_r && last2_r) res_valid_r <= 1'b1;
      else if (res_ready) res_valid_r <= 1'b0;
    end
  end

  assign clr_busy  = clr_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// ===== rtl/cloud_in_cell_deposit_core.sv =====
// Cloud-in-cell deposit core: top level with configuration register.
// Depends on cicd_pkg, cicd_front, cicd_queue, cicd_back and the defines header.
//
// After reset the grid memory is cleared one cell per cycle, all GRID_SIDE^3
// cells, while in_tready stays low. A deposit request (tuser 0) passes
// through the front end (three 28x32 scaling multiplies on one multiplier,
// then a modulo reduction of the whole part by GRID_SIDE) and the back end,
// whose eight read-modify-write accumulations share the one grid memory port;
// the two overlap through a two-entry queue, so the front end can accept a new
// request while the back end is still working on an earlier one. A read
// request (tuser 1) skips the scaling and returns one cell.
// Each request yields one result; a deposit returns mass 0 and a saturation
// flag, a read returns the cell mass in Q16.16.
`default_nettype none
`include "cloud_in_cell_deposit_core_defines.svh"
module cloud_in_cell_deposit_core #(
  parameter int GRID_SIDE = cicd_pkg::GRID_SIDE_DEF,
  parameter int FRAC_BITS = cicd_pkg::FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // pos_x[27:0], pos_y[55:28], pos_z[83:56], read_x[88:84],
  // read_y[93:89], read_z[98:94], zero pad [103:99]
  input  wire  [103:0] in_tdata,
  // kind[0]
  input  wire          in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // cell_mass[31:0]
  output logic [31:0]  out_tdata,
  // saturated[0]
  output logic         out_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [31:0]  cfg_data
);
  import cicd_pkg::*;

  localparam int IDX_W   = $clog2(GRID_SIDE);
  localparam int ENTRY_W = 1 + 6 * IDX_W + 3 * FRAC_BITS;

  logic [CPU_W-1:0]   cpu_r;
  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic               clr_busy;
  cicd_result_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) cpu_r <= CPU_RESET;
    else if (cfg_valid && cfg_ready) cpu_r <= cfg_data;
  end

  cicd_front #(
    .GRID_SIDE(GRID_SIDE), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W), .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .clr_done(!clr_busy),
    .in_valid(in_tvalid), .in_ready(in_tready), .kind(in_tuser),
    .pos_x(in_tdata[27:0]), .pos_y(in_tdata[55:28]), .pos_z(in_tdata[83:56]),
    .read_x(in_tdata[88:84]), .read_y(in_tdata[93:89]), .read_z(in_tdata[98:94]),
    .cells_per_unit(cpu_r),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  cicd_queue #(.W(ENTRY_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(q_rdata)
  );

  cicd_back #(
    .GRID_SIDE(GRID_SIDE), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W), .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
    .clr_busy(clr_busy),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = res.mass;
  assign out_tuser = res.sat;

  `CICD_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !in_tready, "request accepted during clear")
  `CICD_ASSERT_NOW(a_deposit_mass_zero, out_tvalid && out_tuser, out_tdata == '0,
                   "saturated result carries mass")
  `CICD_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "push into full queue")
  `CICD_ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid,
                    "result dropped while stalled")

endmodule
`default_nettype wire
